[rtl/core/grd_pkg.sv]
package grd_pkg;

  localparam int AxisWidth    = 16;
  localparam int TriggerWidth = 15;
  localparam int ButtonWidth  = 19;
  localparam int HatWidth     = 4;
  localparam int AxisCount    = 6;

  // configuration register indexes
  localparam logic [1:0] CFG_THUMB_DZ    = 2'd0;
  localparam logic [1:0] CFG_TRIGGER_DZ  = 2'd1;
  localparam logic [1:0] CFG_WIRELESS    = 2'd2;
  localparam logic [1:0] CFG_EXPECTED_ID = 2'd3;

  // configuration reset values
  localparam logic [6:0] THUMB_DZ_RESET    = 7'd5;
  localparam logic [7:0] TRIGGER_DZ_RESET  = 8'd30;
  localparam logic       WIRELESS_RESET    = 1'b0;
  localparam logic [7:0] EXPECTED_ID_RESET = 8'h31;

  // byte positions relative to the report id, after the wireless offset
  localparam logic [3:0] REL_THUMB_FIRST = 4'd1;
  localparam logic [3:0] REL_THUMB_LAST  = 4'd4;
  localparam logic [3:0] REL_TRIG_LEFT   = 4'd5;
  localparam logic [3:0] REL_TRIG_RIGHT  = 4'd6;
  localparam logic [3:0] REL_BTN_HAT     = 4'd8;
  localparam logic [3:0] REL_BTN_MID     = 4'd9;
  localparam logic [3:0] REL_BTN_LAST    = 4'd10;
  localparam logic [3:0] POS_MAX         = 4'd15;

  localparam logic [7:0] AXIS_CENTER     = 8'd128;
  localparam logic [7:0] AXIS_POS_SPAN   = 8'd127;
  localparam logic [7:0] TRIGGER_SPAN    = 8'd255;
  localparam logic [3:0] HAT_MAX_DIR     = 4'd7;
  localparam logic [3:0] HAT_CENTERED    = 4'd8;
  localparam logic [AxisWidth-1:0] AXIS_POS_LIMIT = 16'h7FFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       report_start;
  } grd_in_t;

  typedef struct packed {
    logic signed [AxisWidth-1:0] left_x;
    logic signed [AxisWidth-1:0] left_y;
    logic signed [AxisWidth-1:0] right_x;
    logic signed [AxisWidth-1:0] right_y;
    logic [TriggerWidth-1:0]     left_trigger;
    logic [TriggerWidth-1:0]     right_trigger;
    logic [ButtonWidth-1:0]      button_mask;
    logic [HatWidth-1:0]         hat_direction;
  } grd_out_t;

  typedef struct packed {
    logic [6:0] thumb_deadzone;
    logic [7:0] trigger_deadzone;
    logic       wireless_mode;
    logic [7:0] expected_report_id;
  } grd_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_write;
    logic out_load;
  } grd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic emit;
    logic out_full;
  } grd_status_t;

endpackage

[rtl/core/grd_ctrl.sv]
module grd_ctrl
  import grd_pkg::*;
#(
  parameter int FRACTION_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  grd_status_t status_i,
  output grd_cmd_t    cmd_o
);

  localparam int CntWidth = $clog2(FRACTION_BITS + 1);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(FRACTION_BITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o          = '0;
    cmd_o.accept   = accept;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && status_i.need_div) begin
          state_d = ST_DIV;
        end else if (accept && status_i.emit) begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.div_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_EMIT: begin
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/core/grd_datapath.sv]
module grd_datapath
  import grd_pkg::*;
#(
  parameter int FRACTION_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  grd_cfg_t    cfg_i,
  input  grd_in_t     in_data_i,
  input  grd_cmd_t    cmd_i,
  output grd_status_t status_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output grd_out_t    out_data_o
);

  localparam int QuoWidth = FRACTION_BITS + 1;

  logic [3:0]           pos_q;
  logic                 dropped_q;
  logic [AxisWidth-1:0] axis_q [AxisCount];
  logic [ButtonWidth-1:0] btn_q;
  logic [HatWidth-1:0]  hat_q;
  logic                 out_valid_q;
  grd_out_t             out_data_q;

  // divider
  logic [8:0]           rem_q;
  logic [7:0]           dvs_q;
  logic [QuoWidth-1:0]  quo_q;
  logic                 neg_q;
  logic [2:0]           idx_q;

  logic [3:0] pos, rel;
  logic       drop_eff, active, is_thumb, is_trig, is_axis;
  logic [7:0] data, dz_thumb, dz_trig;
  logic       lo;
  logic [7:0] thumb_mag, thumb_n, thumb_d, trig_n, trig_d, num, dvs;
  logic       thumb_zero, trig_zero, zero;
  logic [2:0] axis_idx;
  logic [3:0] hat_code;

  assign data     = in_data_i.data_byte;
  assign dz_thumb = {1'b0, cfg_i.thumb_deadzone};
  assign dz_trig  = cfg_i.trigger_deadzone;

  assign pos      = in_data_i.report_start ? 4'd0 : pos_q;
  assign drop_eff = in_data_i.report_start ? 1'b0 : dropped_q;
  assign rel      = pos - {3'b000, cfg_i.wireless_mode};
  assign active   = !drop_eff && (pos != 4'd0);
  assign is_thumb = active && (rel >= REL_THUMB_FIRST) && (rel <= REL_THUMB_LAST);
  assign is_trig  = active && ((rel == REL_TRIG_LEFT) || (rel == REL_TRIG_RIGHT));
  assign is_axis  = is_thumb | is_trig;
  assign axis_idx = 3'(rel - 4'd1);

  // stick: below center is the negative side with one more step of span
  assign lo         = (data < AXIS_CENTER);
  assign thumb_mag  = lo ? (AXIS_CENTER - data) : (data - AXIS_CENTER);
  assign thumb_zero = lo ? (thumb_mag < dz_thumb)
                         : ((thumb_mag == 8'd0) || (thumb_mag < dz_thumb));
  assign thumb_n    = thumb_mag - dz_thumb;
  assign thumb_d    = lo ? (AXIS_CENTER - dz_thumb) : (AXIS_POS_SPAN - dz_thumb);

  assign trig_zero  = (data < dz_trig);
  assign trig_n     = data - dz_trig;
  assign trig_d     = TRIGGER_SPAN - dz_trig;

  assign num  = is_thumb ? thumb_n : trig_n;
  assign dvs  = is_thumb ? thumb_d : trig_d;
  // a zero divisor only comes with a zero numerator
  assign zero = (is_thumb ? thumb_zero : trig_zero) || (dvs == 8'd0);

  assign hat_code = data[3:0];

  assign status_o.need_div = is_axis & !zero;
  assign status_o.emit     = active && (rel == REL_BTN_LAST);
  assign status_o.out_full = out_valid_q & !out_ready_i;

  // one quotient bit per step, numerator never exceeds the divisor
  logic       ge;
  logic [8:0] diff;
  logic [7:0] rem_nxt;
  logic [AxisWidth-1:0] q_ext, axis_val;

  assign ge       = (rem_q >= {1'b0, dvs_q});
  assign diff     = rem_q - {1'b0, dvs_q};
  assign rem_nxt  = ge ? diff[7:0] : rem_q[7:0];
  assign q_ext    = AxisWidth'(quo_q);
  assign axis_val = neg_q ? (AxisWidth'(0) - q_ext)
                          : ((q_ext > AXIS_POS_LIMIT) ? AXIS_POS_LIMIT : q_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      dropped_q <= 1'b0;
      for (int i = 0; i < AxisCount; i++) begin
        axis_q[i] <= '0;
      end
      btn_q     <= '0;
      hat_q     <= HAT_CENTERED;
    end else begin
      if (cmd_i.accept) begin
        pos_q     <= (pos < POS_MAX) ? pos + 4'd1 : POS_MAX;
        dropped_q <= drop_eff | ((pos == 4'd0) && cfg_i.wireless_mode &&
                                 (data != cfg_i.expected_report_id));
        if (is_axis && zero) begin
          axis_q[axis_idx] <= '0;
        end
        if (active && (rel == REL_BTN_HAT)) begin
          btn_q[3:0] <= {data[4], data[5], data[6], data[7]};
          hat_q      <= (hat_code > HAT_MAX_DIR) ? HAT_CENTERED : hat_code;
        end
        if (active && (rel == REL_BTN_MID)) begin
          btn_q[11:4] <= {data[0], data[1], data[2], data[3],
                          data[4], data[5], data[6], data[7]};
        end
        if (active && (rel == REL_BTN_LAST)) begin
          btn_q[14:12] <= data[2:0];
          btn_q[18:15] <= data[7:4];
        end
      end
      if (cmd_i.div_write) begin
        axis_q[idx_q] <= axis_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_axis && !zero) begin
      rem_q <= {1'b0, num};
      dvs_q <= dvs;
      quo_q <= '0;
      neg_q <= is_thumb & lo;
      idx_q <= axis_idx;
    end else if (cmd_i.div_step) begin
      rem_q <= {rem_nxt, 1'b0};
      quo_q <= {quo_q[QuoWidth-2:0], ge};
    end
  end

  // result register, freed by the downstream transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.left_x        <= axis_q[0];
      out_data_q.left_y        <= axis_q[1];
      out_data_q.right_x       <= axis_q[2];
      out_data_q.right_y       <= axis_q[3];
      out_data_q.left_trigger  <= axis_q[4][TriggerWidth-1:0];
      out_data_q.right_trigger <= axis_q[5][TriggerWidth-1:0];
      out_data_q.button_mask   <= btn_q;
      out_data_q.hat_direction <= hat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/core/gamepad_report_decoder_core.sv]
// Gamepad input report decoder. Report bytes arrive one per input transfer,
// with report_start marking the report id byte. With wireless_mode set the
// layout shifts by one byte and reports whose id differs from
// expected_report_id are dropped until the next start. Stick bytes pass a
// symmetric dead zone and are scaled to signed Q1.15, trigger bytes their own
// dead zone and Q0.15; buttons and hat are unpacked from the last three bytes,
// and one result transfer follows the last button byte. An id, button,
// padding or trailing byte, and an axis byte in the dead zone, needs no
// further work; an axis byte outside the dead zone holds off the next byte
// while the shared restoring divider, one quotient bit per cycle, runs and
// the quotient is written back; after the last button byte the next byte
// waits until the result register is loaded, longer while it still holds
// an earlier result that has not been taken. Configuration writes take
// effect on the next byte and should only be issued while the block is idle.
module gamepad_report_decoder_core
  import grd_pkg::*;
#(
  parameter int FRACTION_BITS = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // report byte stream
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  grd_in_t    in_data_i,
  // decoded report
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output grd_out_t   out_data_o,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  grd_cfg_t    cfg_q;
  grd_cmd_t    cmd;
  grd_status_t status;

  // configuration registers, write only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thumb_deadzone     <= THUMB_DZ_RESET;
      cfg_q.trigger_deadzone   <= TRIGGER_DZ_RESET;
      cfg_q.wireless_mode      <= WIRELESS_RESET;
      cfg_q.expected_report_id <= EXPECTED_ID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THUMB_DZ:    cfg_q.thumb_deadzone     <= cfg_wdata_i[6:0];
        CFG_TRIGGER_DZ:  cfg_q.trigger_deadzone   <= cfg_wdata_i;
        CFG_WIRELESS:    cfg_q.wireless_mode      <= cfg_wdata_i[0];
        CFG_EXPECTED_ID: cfg_q.expected_report_id <= cfg_wdata_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // sequencing: byte accept, divider steps, axis write back, result load
  grd_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // decode state, axis scaling divider and result register
  grd_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

[tb/sv/gamepad_report_decoder_core_tb.sv]
module gamepad_report_decoder_core_tb;
  import grd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 15;
  // settle time, derived from how long one axis byte outside the dead zone takes
  localparam int SettleCycles = 4 * (FracBits + 3);
  // receiver hold-off, long enough for two reports to pile up behind it
  localparam int HoldCycles = 600;
  // cycles without any transfer before the run is declared hung
  localparam int StallLimit = 4000;
  localparam int PhaseItems = 150;
  localparam int PhaseCount = 8;
  localparam int MaxPrinted = 100;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  grd_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  grd_out_t   out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  gamepad_report_decoder_core #(
    .FRACTION_BITS(FracBits)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // decoder state as the testbench sees it
  // -------------------------------------------------------------------------
  grd_cfg_t              cur_cfg;
  logic [3:0]            next_pos;
  logic                  drop_rest;
  logic [AxisWidth-1:0]  axis_mem [AxisCount];
  logic [ButtonWidth-1:0] btn_mask;
  logic [HatWidth-1:0]   hat_code;

  grd_out_t pending_reports [$];
  grd_out_t oldest_report;
  int       useful_items;
  int       err_count;
  int       quiet_cycles;
  bit       calm;       // no idling on either side
  bit       hold_req;   // asks the receiver for one long hold-off

  // -------------------------------------------------------------------------
  // directed stimulus, wired layout at reset register values
  // -------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] data_byte;
    logic       report_start;
    logic       typed;
    grd_out_t   value;
  } script_row_t;

  localparam grd_out_t NoValue = '0;
  // full deflection both ways, trigger pinned, every button, hat code above 7
  localparam grd_out_t FullDeflect = '{
    left_x: 16'h8000, left_y: 16'h7FFF, right_x: 16'h0000, right_y: 16'h0000,
    left_trigger: 15'h7FFF, right_trigger: 15'h0000,
    button_mask: 19'h7FFFF, hat_direction: HAT_CENTERED
  };

  localparam int ScriptLen = 25;
  localparam script_row_t Script [ScriptLen] = '{
    // first byte after reset has no start flag and still counts as the id
    '{8'h01, 1'b0, 1'b0, NoValue},
    '{8'h00, 1'b0, 1'b0, NoValue},     // stick at -1.0
    '{8'hFF, 1'b0, 1'b0, NoValue},     // stick at +1.0, saturates
    '{8'h80, 1'b0, 1'b0, NoValue},     // centered
    '{8'h84, 1'b0, 1'b0, NoValue},     // inside the dead zone
    '{8'hFF, 1'b0, 1'b0, NoValue},     // trigger full scale, saturates
    '{8'h1D, 1'b0, 1'b0, NoValue},     // trigger just below its dead zone
    '{8'hA5, 1'b0, 1'b0, NoValue},     // padding
    '{8'hFF, 1'b0, 1'b0, NoValue},     // buttons 0..3, hat code 15
    '{8'hFF, 1'b0, 1'b0, NoValue},
    '{8'hFF, 1'b0, 1'b1, FullDeflect},
    '{8'h5A, 1'b0, 1'b0, NoValue},     // trailing byte
    // short report, abandoned by the next start
    '{8'h00, 1'b1, 1'b0, NoValue},
    '{8'h20, 1'b0, 1'b0, NoValue},
    '{8'hFF, 1'b1, 1'b0, NoValue},
    '{8'h7B, 1'b0, 1'b0, NoValue},     // exactly at the dead zone edge
    '{8'h85, 1'b0, 1'b0, NoValue},
    '{8'h7A, 1'b0, 1'b0, NoValue},     // one step out, negative
    '{8'h86, 1'b0, 1'b0, NoValue},     // one step out, positive
    '{8'h1E, 1'b0, 1'b0, NoValue},     // trigger at its dead zone
    '{8'h1F, 1'b0, 1'b0, NoValue},
    '{8'h00, 1'b0, 1'b0, NoValue},
    '{8'h07, 1'b0, 1'b0, NoValue},     // hat northwest, no buttons
    '{8'h00, 1'b0, 1'b0, NoValue},
    '{8'h08, 1'b0, 1'b0, NoValue}      // unused bit of the last byte set
  };

  // -------------------------------------------------------------------------
  // scaling and byte decode
  // -------------------------------------------------------------------------
  function automatic int unsigned scale_to_q(int unsigned num, int unsigned den,
                                             int unsigned cap);
    int unsigned q;
    if (den == 0) return 0;   // only reached with a zero numerator
    q = (num << FracBits) / den;
    return (q > cap) ? cap : q;
  endfunction

  function automatic logic [AxisWidth-1:0] stick_value(logic [7:0] b, logic [6:0] dz);
    int unsigned mag;
    int unsigned q;
    if (b < AXIS_CENTER) begin
      mag = AXIS_CENTER - b;
      if (mag < dz) return '0;
      q = scale_to_q(mag - dz, AXIS_CENTER - dz, 32768);
      return 16'(32'd0 - q);
    end
    mag = b - AXIS_CENTER;
    if (mag == 0 || mag < dz) return '0;
    return 16'(scale_to_q(mag - dz, AXIS_POS_SPAN - dz, 32'h7FFF));
  endfunction

  function automatic logic [TriggerWidth-1:0] trigger_value(logic [7:0] b, logic [7:0] dz);
    if (b < dz) return '0;
    return 15'(scale_to_q(b - dz, TRIGGER_SPAN - dz, 32'h7FFF));
  endfunction

  // advances the decoder by one byte, returns the report it completes
  function automatic void decode_byte(input logic [7:0] b, input logic st,
                                      output logic emitted, output logic used,
                                      output grd_out_t rep);
    logic [3:0] pos;
    logic [3:0] rel;
    int k;
    emitted = 1'b0;
    used    = 1'b0;
    rep     = '0;
    pos = st ? 4'd0 : next_pos;
    if (st) drop_rest = 1'b0;
    next_pos = (pos < POS_MAX) ? pos + 4'd1 : POS_MAX;
    if (drop_rest) return;
    used = (pos <= REL_BTN_LAST + cur_cfg.wireless_mode);
    if (pos == 4'd0) begin
      if (cur_cfg.wireless_mode && b != cur_cfg.expected_report_id) drop_rest = 1'b1;
      return;
    end
    rel = pos - {3'b000, cur_cfg.wireless_mode};
    if (rel >= REL_THUMB_FIRST && rel <= REL_THUMB_LAST) begin
      axis_mem[rel - 1] = stick_value(b, cur_cfg.thumb_deadzone);
    end else if (rel == REL_TRIG_LEFT || rel == REL_TRIG_RIGHT) begin
      axis_mem[rel - 1] = {1'b0, trigger_value(b, cur_cfg.trigger_deadzone)};
    end else if (rel == REL_BTN_HAT) begin
      // buttons come msb first
      for (k = 0; k < 4; k++) btn_mask[k] = b[7 - k];
      hat_code = (b[3:0] > HAT_MAX_DIR) ? HAT_CENTERED : b[3:0];
    end else if (rel == REL_BTN_MID) begin
      for (k = 0; k < 8; k++) btn_mask[4 + k] = b[7 - k];
    end else if (rel == REL_BTN_LAST) begin
      btn_mask[14:12] = b[2:0];
      btn_mask[18:15] = b[7:4];
      rep.left_x        = axis_mem[0];
      rep.left_y        = axis_mem[1];
      rep.right_x       = axis_mem[2];
      rep.right_y       = axis_mem[3];
      rep.left_trigger  = axis_mem[4][TriggerWidth-1:0];
      rep.right_trigger = axis_mem[5][TriggerWidth-1:0];
      rep.button_mask   = btn_mask;
      rep.hat_direction = hat_code;
      emitted = 1'b1;
    end
  endfunction

  // random byte, often one that sits on a scaling edge for the current setup
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3) != 0) return 8'($urandom);
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return AXIS_CENTER;
      3: return AXIS_CENTER - 8'd1;
      4: return AXIS_CENTER + 8'd1;
      5: return AXIS_CENTER - {1'b0, cur_cfg.thumb_deadzone};
      6: return AXIS_CENTER + {1'b0, cur_cfg.thumb_deadzone};
      7: return AXIS_CENTER - {1'b0, cur_cfg.thumb_deadzone} + 8'd1;
      8: return cur_cfg.trigger_deadzone;
      default: return cur_cfg.trigger_deadzone - 8'd1;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // reporting and result check
  // -------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    if (err_count < MaxPrinted) $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // -------------------------------------------------------------------------
  // input side: one byte per transfer, valid held until taken
  // -------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic st, input logic typed,
                           input grd_out_t typed_val);
    logic emitted;
    logic used;
    grd_out_t predicted;
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, report_start: st};
    do @(posedge clk); while (!in_ready);
    decode_byte(b, st, emitted, used, predicted);
    if (used) useful_items++;
    if (typed) pending_reports.push_back(typed_val);
    else if (emitted) pending_reports.push_back(predicted);
  endtask

  // sender pauses until every report is out and the divider has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // register writes, only issued while the block is idle
  task automatic apply_config(input grd_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THUMB_DZ;
    cfg_wdata <= {1'($urandom_range(1)), c.thumb_deadzone};
    @(posedge clk);
    cfg_index <= CFG_TRIGGER_DZ;
    cfg_wdata <= c.trigger_deadzone;
    @(posedge clk);
    cfg_index <= CFG_WIRELESS;
    cfg_wdata <= {7'($urandom), c.wireless_mode};
    @(posedge clk);
    cfg_index <= CFG_EXPECTED_ID;
    cfg_wdata <= c.expected_report_id;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_cfg  = c;
  endtask

  // mostly whole reports with random content, some short, long or broken
  task automatic run_phase(input grd_cfg_t c);
    int first;
    int pick;
    int len;
    int whole;
    int n;
    logic [7:0] id;
    apply_config(c);
    first = useful_items;
    // bytes without a start continue whatever report the last phase left open
    repeat ($urandom_range(6)) send_byte(pick_byte(), 1'b0, 1'b0, NoValue);
    while (useful_items - first < PhaseItems) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_byte(pick_byte(), 1'($urandom_range(1)), 1'b0, NoValue);
      end else begin
        whole = REL_BTN_LAST + 1 + cur_cfg.wireless_mode;
        if (pick < 13) len = $urandom_range(whole - 1, 1);
        else if (pick < 20) len = whole + $urandom_range(8, 1);
        else len = whole;
        id = (cur_cfg.wireless_mode && $urandom_range(9) != 0) ?
             cur_cfg.expected_report_id : 8'($urandom);
        send_byte(id, 1'b1, 1'b0, NoValue);
        for (n = 1; n < len; n++)
          send_byte(pick_byte(), 1'($urandom_range(99) == 0), 1'b0, NoValue);
      end
    end
    // leave a report open across the next register update
    send_byte(cur_cfg.expected_report_id, 1'b1, 1'b0, NoValue);
    repeat ($urandom_range(4)) send_byte(pick_byte(), 1'b0, 1'b0, NoValue);
  endtask

  // -------------------------------------------------------------------------
  // output side: random back-pressure plus one long hold-off
  // -------------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // every result transfer is compared with the oldest pending report
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        flag_error("result transfer with no report pending");
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("left_x", out_data.left_x, oldest_report.left_x);
        check_field("left_y", out_data.left_y, oldest_report.left_y);
        check_field("right_x", out_data.right_x, oldest_report.right_x);
        check_field("right_y", out_data.right_y, oldest_report.right_y);
        check_field("left_trigger", out_data.left_trigger, oldest_report.left_trigger);
        check_field("right_trigger", out_data.right_trigger, oldest_report.right_trigger);
        check_field("button_mask", out_data.button_mask, oldest_report.button_mask);
        check_field("hat_direction", out_data.hat_direction, oldest_report.hat_direction);
      end
    end
  end

  // hang detection: no transfer on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("gamepad_report_decoder_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    grd_cfg_t c;
    int i;
    int p;
    rst_n = 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_THUMB_DZ;
    cfg_wdata <= '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    err_count    = 0;
    useful_items = 0;
    quiet_cycles = 0;
    cur_cfg = '{thumb_deadzone: THUMB_DZ_RESET, trigger_deadzone: TRIGGER_DZ_RESET,
                wireless_mode: WIRELESS_RESET, expected_report_id: EXPECTED_ID_RESET};
    next_pos  = '0;
    drop_rest = 1'b0;
    for (i = 0; i < AxisCount; i++) axis_mem[i] = '0;
    btn_mask = '0;
    hat_code = HAT_CENTERED;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < ScriptLen; i++)
      send_byte(Script[i].data_byte, Script[i].report_start, Script[i].typed,
                Script[i].value);
    settle();

    for (p = 0; p < PhaseCount; p++) begin
      case (p)
        // smallest dead zones, wired
        0: c = '{thumb_deadzone: 7'd0, trigger_deadzone: 8'd0,
                 wireless_mode: 1'b0, expected_report_id: EXPECTED_ID_RESET};
        // largest dead zones hit the zero divisor, wireless with id zero
        1: c = '{thumb_deadzone: 7'd127, trigger_deadzone: 8'd255,
                 wireless_mode: 1'b1, expected_report_id: 8'h00};
        2: c = '{thumb_deadzone: 7'd100, trigger_deadzone: 8'd200,
                 wireless_mode: 1'b1, expected_report_id: 8'hFF};
        default: c = '{thumb_deadzone: 7'($urandom), trigger_deadzone: 8'($urandom),
                       wireless_mode: 1'($urandom), expected_report_id: 8'($urandom)};
      endcase
      hold_req = (p == 1);   // receiver stalls while reports keep coming
      calm     = (p == 2);   // full-rate stretch
      run_phase(c);
      settle();
    end
    calm = 1'b0;

    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("gamepad_report_decoder_core_tb OK");
    end else begin
      $display("gamepad_report_decoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[gamepad_report_decoder_core.f]
rtl/core/grd_pkg.sv
rtl/core/grd_ctrl.sv
rtl/core/grd_datapath.sv
rtl/core/gamepad_report_decoder_core.sv
tb/sv/gamepad_report_decoder_core_tb.sv
